### sv/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and constants for the LCG range draw and dice sum block.
// ----------------------------------------------------------------------------
package lrd_pkg;

  // Field widths
  localparam int SeedW  = 32;
  localparam int RangeW = 16;
  localparam int CountW = 8;
  localparam int ValueW = 24;
  localparam int RawW   = 14;
  localparam int CmdW   = 2;

  // Generator constants
  localparam logic [SeedW-1:0] LcgMul = 32'd11109;
  localparam logic [SeedW-1:0] LcgAdd = 32'd13849;

  // Command codes
  localparam logic [CmdW-1:0] CmdLoad = 2'd0;
  localparam logic [CmdW-1:0] CmdDraw = 2'd1;
  localparam logic [CmdW-1:0] CmdDice = 2'd2;

  // Configuration register indexes
  localparam logic CfgForceEn    = 1'b0;
  localparam logic CfgForcedSeed = 1'b1;

  // Start request to the modulo unit
  typedef struct packed {
    logic              start;
    logic [RawW-1:0]   dividend;
    logic [RangeW-1:0] divisor;
  } mod_req_t;

endpackage

### sv/lrd_lcg_step.sv
// ----------------------------------------------------------------------------
// lrd_lcg_step
// One generator step: next seed = seed * 11109 + 13849, modulo 2^32.
// ----------------------------------------------------------------------------
module lrd_lcg_step (
  input  logic [lrd_pkg::SeedW-1:0] seed_i,
  output logic [lrd_pkg::SeedW-1:0] seed_o
);
  import lrd_pkg::*;

  // The constant factor is 14 bits wide, so this is a small multiplier.
  assign seed_o = SeedW'(seed_i * LcgMul) + LcgAdd;

endmodule

### sv/lrd_mod_unit.sv
// ----------------------------------------------------------------------------
// lrd_mod_unit
// Iterative remainder unit: one restoring subtract step per cycle.
// ----------------------------------------------------------------------------
module lrd_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lrd_pkg::mod_req_t          req,
  output logic                       done_o,
  output logic [lrd_pkg::RangeW-1:0] rem_o
);
  import lrd_pkg::*;

  localparam int StepW = $clog2(RawW + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(RawW - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [RawW-1:0]   dvd_r, dvd_nxt;
  logic [RangeW-1:0] div_r, div_nxt;
  logic [RangeW-1:0] rem_r, rem_nxt;
  logic [RangeW:0]   trial;

  // Shift the next dividend bit into the partial remainder and subtract if it fits.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[RawW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = RangeW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[RangeW-1:0];
      end
      dvd_nxt  = {dvd_r[RawW-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

### sv/lcg_range_draw_and_dice_sum_top.sv
// A seed load, a zero range, zero dice or an unused command gives its item
// without a draw; a dice roll with a nonzero range makes one draw per die.
// Each draw runs one generator step, one unit start, 14 remainder steps in the
// shared subtract unit, and the collection of the remainder.
// One item at a time; the next is taken once the result has been posted.
// Reset (synchronous, active low) clears seed, draw count and config registers.
// ----------------------------------------------------------------------------
// lcg_range_draw_and_dice_sum_top
// Seeded linear congruential generator with ranged draws and dice sums.
// ----------------------------------------------------------------------------
module lcg_range_draw_and_dice_sum_top #(
  parameter int MAX_DICE = 255
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input item
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [55:0]               in_tdata,  // seed_value, range_or_sides, dice_count
  input  logic [lrd_pkg::CmdW-1:0]  in_tuser,  // command
  // Result item
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [55:0]               out_tdata, // value, draws_total
  // Configuration
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [lrd_pkg::SeedW-1:0] cfg_wdata
);
  import lrd_pkg::*;

  localparam logic [CountW-1:0] MaxDiceCap =
    (MAX_DICE > 255) ? 8'd255 : CountW'(MAX_DICE);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLcg  = 3'd1;
  localparam logic [2:0] StMst  = 3'd2;
  localparam logic [2:0] StMod  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [SeedW-1:0]  seed_r, seed_nxt;
  logic [SeedW-1:0]  draws_r, draws_nxt;
  logic              force_en_r;
  logic [SeedW-1:0]  pinned_seed_r;
  logic [RangeW-1:0] range_r, range_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic              single_r, single_nxt;
  logic [ValueW-1:0] sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ValueW-1:0] out_value_r, out_value_nxt;
  logic [SeedW-1:0]  out_total_r, out_total_nxt;

  logic [CmdW-1:0]   in_cmd;
  logic [SeedW-1:0]  in_seed;
  logic [RangeW-1:0] in_range;
  logic [CountW-1:0] in_count;
  logic [CountW-1:0] eff_count;
  logic [SeedW-1:0]  seed_step;
  mod_req_t          mod_req;
  logic              mod_done;
  logic [RangeW-1:0] mod_rem;
  logic [ValueW:0]   acc;

  // Unpack the input item
  assign in_cmd    = in_tuser;
  assign in_seed   = in_tdata[31:0];
  assign in_range  = in_tdata[47:32];
  assign in_count  = in_tdata[55:48];
  assign eff_count = (in_count > MaxDiceCap) ? MaxDiceCap : in_count;

  assign in_tready = (state_r == StIdle);

  lrd_lcg_step u_lcg (
    .seed_i (seed_r),
    .seed_o (seed_step)
  );

  lrd_mod_unit u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // Running dice sum with saturation at the field maximum
  assign acc = {1'b0, sum_r} + (ValueW+1)'(mod_rem) + (ValueW+1)'(1);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    draws_nxt     = draws_r;
    range_nxt     = range_r;
    cnt_nxt       = cnt_r;
    single_nxt    = single_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_total_nxt = out_total_r;
    mod_req       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      StIdle: begin
        if (in_tvalid) begin
          range_nxt = in_range;
          sum_nxt   = '0;
          case (in_cmd)
            CmdLoad: begin
              seed_nxt  = force_en_r ? pinned_seed_r : in_seed;
              state_nxt = StFin;
            end
            CmdDraw: begin
              single_nxt = 1'b1;
              cnt_nxt    = CountW'(1);
              state_nxt  = (in_range == '0) ? StFin : StLcg;
            end
            CmdDice: begin
              single_nxt = 1'b0;
              cnt_nxt    = eff_count;
              // With zero sides every die counts one and nothing advances.
              if (in_range == '0) begin
                sum_nxt = ValueW'(eff_count);
              end
              state_nxt = (in_range == '0 || eff_count == '0) ? StFin : StLcg;
            end
            default: begin
              state_nxt = StFin;
            end
          endcase
        end
      end
      StLcg: begin
        seed_nxt  = seed_step;
        draws_nxt = draws_r + 1'b1;
        state_nxt = StMst;
      end
      StMst: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = seed_r[RawW:1];
        mod_req.divisor  = range_r;
        state_nxt        = StMod;
      end
      StMod: begin
        if (mod_done) begin
          if (single_r) begin
            sum_nxt   = ValueW'(mod_rem);
            state_nxt = StFin;
          end else begin
            sum_nxt   = acc[ValueW] ? '1 : acc[ValueW-1:0];
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = (cnt_r == CountW'(1)) ? StFin : StLcg;
          end
        end
      end
      StFin: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = sum_r;
          out_total_nxt = draws_r;
          state_nxt     = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  // Control state, generator state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= StIdle;
      seed_r        <= '0;
      draws_r       <= '0;
      out_valid_r   <= 1'b0;
      force_en_r    <= 1'b0;
      pinned_seed_r <= '0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      draws_r     <= draws_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CfgForceEn:    force_en_r    <= cfg_wdata[0];
          CfgForcedSeed: pinned_seed_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    range_r     <= range_nxt;
    cnt_r       <= cnt_nxt;
    single_r    <= single_nxt;
    sum_r       <= sum_nxt;
    out_value_r <= out_value_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_value_r};

endmodule

### sv/lrd_checker.sv
// ----------------------------------------------------------------------------
// lrd_checker
// Port-level checks for the LCG range draw and dice sum block.
// ----------------------------------------------------------------------------
module lrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Only one item is in work: ready drops right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Ready returns only once the result has been posted.
  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> out_tvalid)
    else $error("ready returned without a result");

endmodule

bind lcg_range_draw_and_dice_sum_top lrd_checker u_lrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCG range draw and dice sum block.
// A short table of directed items runs first: the range and count extremes,
// every command, zero sides, zero dice, the unused command and forced seed
// loads. Random phases follow, each with its own register setting. Every
// accepted item is run through a local generator model, and each result
// item is compared field by field with the oldest expected result. Both
// sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lrd_pkg::*;

  localparam int MaxDice       = 255;
  localparam int PhaseCount    = 7;
  localparam int PhaseItems    = 100;
  localparam int CycleLimit    = 20_000_000;
  localparam int ReportLimit   = 10;
  localparam int DrainCycles   = 20;

  // The fourth command code does nothing in the block.
  localparam logic [CmdW-1:0] CmdNone = 2'd3;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [SeedW-1:0]  total;
  } result_t;

  typedef struct {
    logic              is_cfg;
    logic              cfg_index;
    logic [CmdW-1:0]   cmd;
    logic [SeedW-1:0]  word;
    logic [RangeW-1:0] modulus;
    logic [CountW-1:0] count;
    logic              fixed;
    result_t           fixed_res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [55:0]       in_tdata;   // seed_value, range_or_sides, dice_count
  logic [CmdW-1:0]   in_tuser;   // command
  logic              out_tvalid;
  logic              out_tready;
  logic [55:0]       out_tdata;  // value, draws_total
  logic              cfg_we;
  logic              cfg_addr;
  logic [SeedW-1:0]  cfg_wdata;

  // Generator model state and its copy of the registers
  logic [SeedW-1:0]  lcg_seed;
  logic [SeedW-1:0]  draw_cnt;
  logic              force_en;
  logic [SeedW-1:0]  pinned_seed;

  result_t           pending_results[$];
  int                mism_cnt;
  logic              calm;
  int                stall_left;
  logic              cur_fixed;
  result_t           cur_fixed_res;
  stim_row_t         dir_tab[$];

  lcg_range_draw_and_dice_sum_top #(
    .MAX_DICE(MaxDice)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 20 unit period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One generator step and ranged draw; a zero range leaves the state alone.
  function automatic logic [SeedW-1:0] lcg_draw(input logic [RangeW-1:0] modulus);
    logic [RawW-1:0] raw;
    if (modulus == '0) return '0;
    lcg_seed = lcg_seed * LcgMul + LcgAdd;
    raw      = lcg_seed[RawW:1];
    draw_cnt = draw_cnt + 32'd1;
    return {18'd0, raw} % {16'd0, modulus};
  endfunction

  // Expected result of one item; advances the model state.
  function automatic result_t predict_item(input logic [CmdW-1:0] cmd,
                                           input logic [SeedW-1:0] word,
                                           input logic [RangeW-1:0] modulus,
                                           input logic [CountW-1:0] count);
    result_t          r;
    logic [63:0]      sum;
    logic [SeedW-1:0] one_draw;
    int               n;
    r.value = '0;
    case (cmd)
      CmdLoad: lcg_seed = force_en ? pinned_seed : word;
      CmdDraw: begin
        one_draw = lcg_draw(modulus);
        r.value  = one_draw[ValueW-1:0];
      end
      CmdDice: begin
        n   = (int'(count) > MaxDice) ? MaxDice : int'(count);
        sum = '0;
        for (int i = 0; i < n; i++) begin
          one_draw = lcg_draw(modulus);
          sum      = sum + {32'd0, one_draw} + 64'd1;
        end
        r.value = (sum > 64'hFF_FFFF) ? 24'hFF_FFFF : sum[ValueW-1:0];
      end
      default: ;
    endcase
    r.total = draw_cnt;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [CmdW-1:0] cmd,
                                         input logic [SeedW-1:0] word,
                                         input logic [RangeW-1:0] modulus,
                                         input logic [CountW-1:0] count,
                                         input logic fixed,
                                         input logic [ValueW-1:0] value,
                                         input logic [SeedW-1:0] total);
    stim_row_t r;
    r.is_cfg          = 1'b0;
    r.cfg_index       = CfgForceEn;
    r.cmd             = cmd;
    r.word            = word;
    r.modulus         = modulus;
    r.count           = count;
    r.fixed           = fixed;
    r.fixed_res.value = value;
    r.fixed_res.total = total;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [SeedW-1:0] data);
    stim_row_t r;
    r           = item_row(CmdNone, data, '0, '0, 1'b0, '0, '0);
    r.is_cfg    = 1'b1;
    r.cfg_index = idx;
    return r;
  endfunction

  // Sender gaps: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until accepted, then idle for a random gap, possibly none.
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [SeedW-1:0] word,
                           input logic [RangeW-1:0] modulus, input logic [CountW-1:0] count,
                           input logic fixed, input result_t fixed_res);
    int gap;
    in_tvalid     <= 1'b1;
    in_tuser      <= cmd;
    in_tdata      <= {count, modulus, word};
    cur_fixed     <= fixed;
    cur_fixed_res <= fixed_res;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [SeedW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver back-pressure: random stalls, mostly short, a few long.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Track register writes, predict accepted items and check result items.
  always @(posedge clk) begin
    result_t p;
    result_t got;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_addr == CfgForceEn) force_en = cfg_wdata[0];
        else                        pinned_seed = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        p = predict_item(in_tuser, in_tdata[31:0], in_tdata[47:32], in_tdata[55:48]);
        pending_results.push_back(cur_fixed ? cur_fixed_res : p);
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[23:0];
        got.total = out_tdata[55:24];
        if (pending_results.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= ReportLimit)
            $display("unexpected result item: value %h total %h", got.value, got.total);
        end else begin
          p = pending_results.pop_front();
          if (got.value !== p.value || got.total !== p.total) begin
            mism_cnt++;
            if (mism_cnt <= ReportLimit)
              $display("result mismatch: value exp %h got %h, total exp %h got %h",
                       p.value, got.value, p.total, got.total);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    stim_row_t         row;
    logic [CmdW-1:0]   cmd;
    logic [SeedW-1:0]  word;
    logic [RangeW-1:0] modulus;
    logic [CountW-1:0] count;
    int                roll;
    result_t           none_res;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CmdLoad;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = CfgForceEn;
    cfg_wdata   = '0;
    lcg_seed    = '0;
    draw_cnt    = '0;
    force_en    = 1'b0;
    pinned_seed = '0;
    mism_cnt    = 0;
    calm        = 1'b0;
    stall_left  = 0;
    cur_fixed   = 1'b0;
    none_res    = '0;
    cur_fixed_res = '0;

    // Rows with a typed result come right after reset, where the seed is zero.
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd0, 8'd0, 1'b1, 24'd0, 32'd0));
    dir_tab.push_back(item_row(CmdNone, '1, '1, '1, 1'b1, 24'd0, 32'd0));
    dir_tab.push_back(item_row(CmdLoad, '0, '0, '0, 1'b1, 24'd0, 32'd0));
    dir_tab.push_back(item_row(CmdDice, '0, 16'd0, 8'd255, 1'b1, 24'd255, 32'd0));
    dir_tab.push_back(item_row(CmdDice, '0, 16'd7, 8'd0, 1'b1, 24'd0, 32'd0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd1, 8'd0, 1'b1, 24'd0, 32'd1));
    dir_tab.push_back(item_row(CmdDice, '0, 16'd1, 8'd3, 1'b1, 24'd3, 32'd4));
    dir_tab.push_back(item_row(CmdLoad, '1, 16'd0, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'hFFFF, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd16384, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd16383, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDice, '0, 16'hFFFF, 8'd255, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDice, '0, 16'd6, 8'd1, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd2, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdLoad, 32'h1234_5678, '1, '1, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDice, '0, 16'd0, 8'd1, 1'b0, '0, '0));
    // Forced loads ignore the seed field of the item.
    dir_tab.push_back(cfg_row(CfgForceEn, 32'd1));
    dir_tab.push_back(cfg_row(CfgForcedSeed, '1));
    dir_tab.push_back(item_row(CmdLoad, '0, 16'd0, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd100, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(cfg_row(CfgForcedSeed, '0));
    dir_tab.push_back(item_row(CmdLoad, 32'h5555_AAAA, 16'd0, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd16384, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(cfg_row(CfgForceEn, 32'd0));
    dir_tab.push_back(item_row(CmdLoad, 32'hA5A5_A5A5, 16'd0, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDraw, '0, 16'd6, 8'd0, 1'b0, '0, '0));
    dir_tab.push_back(item_row(CmdDice, '0, 16'd6, 8'd2, 1'b0, '0, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        drain_results();
        cfg_write(row.cfg_index, row.word);
      end else begin
        send_item(row.cmd, row.word, row.modulus, row.count, row.fixed, row.fixed_res);
      end
    end

    // Random phases, each under a new register setting.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      calm = (phase == 3);
      case (phase)
        0: begin
          cfg_write(CfgForceEn, $urandom() | 32'd1);
          cfg_write(CfgForcedSeed, '1);
        end
        1: begin
          cfg_write(CfgForceEn, $urandom() & ~32'd1);
          cfg_write(CfgForcedSeed, '0);
        end
        2: begin
          cfg_write(CfgForceEn, 32'd1);
          cfg_write(CfgForcedSeed, '0);
        end
        default: begin
          cfg_write(CfgForceEn, $urandom());
          cfg_write(CfgForcedSeed, $urandom());
        end
      endcase

      for (int k = 0; k < PhaseItems; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 15)      cmd = CmdLoad;
        else if (roll < 55) cmd = CmdDraw;
        else if (roll < 90) cmd = CmdDice;
        else                cmd = CmdNone;
        word = $urandom();

        // Moduli: zero, small, medium, full width and around the raw ceiling.
        roll = $urandom_range(0, 99);
        if (roll < 10)      modulus = '0;
        else if (roll < 50) modulus = RangeW'($urandom_range(1, 16));
        else if (roll < 70) modulus = RangeW'($urandom_range(17, 1000));
        else if (roll < 85) modulus = RangeW'($urandom());
        else if (roll < 95) modulus = RangeW'($urandom_range(16383, 16385));
        else                modulus = '1;

        // Dice counts stay small but for a few long rolls.
        roll = $urandom_range(0, 99);
        if (roll < 85)      count = CountW'($urandom_range(0, 6));
        else if (roll < 95) count = CountW'($urandom_range(7, 31));
        else if (roll < 99) count = CountW'($urandom_range(0, 255));
        else                count = 8'd255;

        if (cmd == CmdLoad || cmd == CmdNone) begin
          modulus = RangeW'($urandom());
          count   = CountW'($urandom());
        end
        send_item(cmd, word, modulus, count, 1'b0, none_res);
      end
    end

    // Let the last results come back, then allow for stray ones.
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mism_cnt == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
